/* hw/rtl/stq_pkg.sv */
package stq_pkg;

  localparam int unsigned MAX_ELEMENTS = 1024;
  localparam int unsigned VALUE_BITS   = 32;
  localparam int unsigned LEVEL_COUNT  = 11;

  localparam int unsigned IDX_BITS    = $clog2(MAX_ELEMENTS);
  localparam int unsigned CNT_BITS    = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned LEVEL_BITS  = $clog2(CNT_BITS);
  localparam int unsigned ADDR_BITS   = LEVEL_BITS + IDX_BITS;
  localparam int unsigned TABLE_DEPTH = LEVEL_COUNT * MAX_ELEMENTS;
  localparam int unsigned SPAN_BITS   = CNT_BITS + 1;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    MODE_UMIN = 2'd0,
    MODE_UMAX = 2'd1,
    MODE_SMIN = 2'd2,
    MODE_SMAX = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_QRD1,
    S_QRD2,
    S_RESULT
  } fsm_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] element_value;
    logic [9:0]  left_index;
    logic [10:0] right_index;
  } in_item_t;

  typedef struct packed {
    logic [31:0] range_answer;
    logic [1:0]  status;
  } out_item_t;

  function automatic logic [VALUE_BITS-1:0] combine(input logic [VALUE_BITS-1:0] a,
                                                    input logic [VALUE_BITS-1:0] b,
                                                    input logic [1:0] mode);
    logic [VALUE_BITS-1:0] ka;
    logic [VALUE_BITS-1:0] kb;
    logic                  pick_a;
    ka = a;
    kb = b;
    if (mode == MODE_SMIN || mode == MODE_SMAX) begin
      ka[VALUE_BITS-1] = ~a[VALUE_BITS-1];
      kb[VALUE_BITS-1] = ~b[VALUE_BITS-1];
    end
    if (mode == MODE_UMAX || mode == MODE_SMAX) begin
      pick_a = (ka >= kb);
    end else begin
      pick_a = (ka <= kb);
    end
    return pick_a ? a : b;
  endfunction

endpackage

/* hw/rtl/stq_ram.sv */
module stq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/sparse_table_range_query_unit.sv */
// Sparse table range min/max unit.
// Append: writes level 0, then one read-modify-write of the table memory per upper level
//   updated (up to LEVEL_COUNT-1 upper levels).
// Query: two table reads on the single read port. Clear: resets the element count.
// One item at a time; result held in an output register.
// Reset clears element count, mode and control; table contents stay undefined.
module sparse_table_range_query_unit
  import stq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o,
  input  logic      cfg_we_i,
  input  logic [1:0] cfg_wdata_i
);

  fsm_e                  state_q, state_d;
  logic [CNT_BITS-1:0]   count_q, count_d;
  logic [1:0]            mode_q;
  logic [CNT_BITS-1:0]   n1_q, n1_d;
  logic [LEVEL_BITS-1:0] k_q, k_d;
  logic [LEVEL_BITS-1:0] qlvl_q, qlvl_d;
  logic [IDX_BITS-1:0]   qsec_q, qsec_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;
  out_item_t             res_q, res_d;
  out_item_t             out_q, out_d;
  logic                  out_valid_q, out_valid_d;

  logic                  mem_we, mem_re;
  logic [ADDR_BITS-1:0]  mem_waddr, mem_raddr;
  logic [VALUE_BITS-1:0] mem_wdata, mem_rdata;

  logic                  accept;
  logic [CNT_BITS-1:0]   q_left, q_len, q_second;
  logic [LEVEL_BITS-1:0] q_lvl;
  logic                  q_ok;
  logic [SPAN_BITS-1:0]  span_cur, span_next;
  logic [SPAN_BITS-1:0]  start_cur, start_next;
  logic                  more_levels;
  logic [VALUE_BITS-1:0] comb_res;

  stq_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    q_left = CNT_BITS'(in_item_i.left_index);
    q_ok   = (q_left < in_item_i.right_index) && (in_item_i.right_index <= count_q);
    q_len  = in_item_i.right_index - q_left;
    q_lvl  = '0;
    for (int i = 0; i < CNT_BITS; i++) begin
      if (q_len[i]) begin
        q_lvl = LEVEL_BITS'(i);
      end
    end
    if (q_lvl > LEVEL_BITS'(LEVEL_COUNT - 1)) begin
      q_lvl = LEVEL_BITS'(LEVEL_COUNT - 1);
    end
    q_second = in_item_i.right_index - (CNT_BITS'(1) << q_lvl);
    if (q_second >= CNT_BITS'(MAX_ELEMENTS)) begin
      q_second = q_left;
    end
  end

  always_comb begin
    span_cur    = SPAN_BITS'(1) << k_q;
    span_next   = SPAN_BITS'(1) << ({1'b0, k_q} + 1'b1);
    start_cur   = SPAN_BITS'(n1_q) - span_cur;
    start_next  = SPAN_BITS'(n1_q) - span_next;
    more_levels = (({1'b0, k_q} + 1'b1) < (LEVEL_BITS + 1)'(LEVEL_COUNT))
                  && (SPAN_BITS'(n1_q) >= span_next);
    comb_res    = combine(mem_rdata, acc_q, mode_q);
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    n1_d        = n1_q;
    k_d         = k_q;
    qlvl_d      = qlvl_q;
    qsec_d      = qsec_q;
    acc_d       = acc_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_item_i.opcode)
            OP_CLEAR: begin
              count_d = '0;
            end
            OP_APPEND: begin
              if (count_q >= CNT_BITS'(MAX_ELEMENTS)) begin
                res_d   = '{range_answer: '0, status: STATUS_FULL};
                state_d = S_RESULT;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = {LEVEL_BITS'(0), count_q[IDX_BITS-1:0]};
                mem_wdata = in_item_i.element_value;
                acc_d     = in_item_i.element_value;
                n1_d      = count_q + 1'b1;
                count_d   = count_q + 1'b1;
                k_d       = LEVEL_BITS'(1);
                res_d     = '{range_answer: '0, status: STATUS_OK};
                if (LEVEL_COUNT > 1 && count_q != '0) begin
                  mem_re    = 1'b1;
                  mem_raddr = {LEVEL_BITS'(0), IDX_BITS'(count_q - 1'b1)};
                  state_d   = S_APPEND;
                end else begin
                  state_d = S_RESULT;
                end
              end
            end
            OP_QUERY: begin
              if (!q_ok) begin
                res_d   = '{range_answer: '0, status: STATUS_RANGE};
                state_d = S_RESULT;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = {q_lvl, in_item_i.left_index};
                qlvl_d    = q_lvl;
                qsec_d    = q_second[IDX_BITS-1:0];
                state_d   = S_QRD1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_APPEND: begin
        mem_we    = 1'b1;
        mem_waddr = {k_q, start_cur[IDX_BITS-1:0]};
        mem_wdata = comb_res;
        acc_d     = comb_res;
        if (more_levels) begin
          mem_re    = 1'b1;
          mem_raddr = {k_q, start_next[IDX_BITS-1:0]};
          k_d       = k_q + 1'b1;
        end else begin
          state_d = S_RESULT;
        end
      end
      S_QRD1: begin
        acc_d     = mem_rdata;
        mem_re    = 1'b1;
        mem_raddr = {qlvl_q, qsec_q};
        state_d   = S_QRD2;
      end
      S_QRD2: begin
        res_d   = '{range_answer: combine(acc_q, mem_rdata, mode_q), status: STATUS_OK};
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      mode_q      <= MODE_UMIN;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n1_q   <= n1_d;
    k_q    <= k_d;
    qlvl_q <= qlvl_d;
    qsec_q <= qsec_d;
    acc_q  <= acc_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_BITS'(MAX_ELEMENTS))
    else $error("element count above capacity");

  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o)
    else $error("item accepted while busy");

  a_rw_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("table read and write hit the same entry");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_APPEND) |-> (k_q < LEVEL_BITS'(LEVEL_COUNT) && k_q != '0))
    else $error("append level out of range");

endmodule

/* bench/sparse_table_range_query_unit_tb.sv */
module sparse_table_range_query_unit_tb;
  import stq_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned SMALL_ITEMS = 1000;
  localparam int unsigned MAX_GAP = 17;
  localparam int unsigned SETTLE_CYCLES = 20;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } script_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;
  logic      cfg_we_i = 1'b0;
  logic [1:0] cfg_wdata_i = 2'd0;

  sparse_table_range_query_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow of the table state
  logic [VALUE_BITS-1:0] shadow_table [LEVEL_COUNT][MAX_ELEMENTS];
  int unsigned shadow_count = 0;
  mode_e       shadow_mode = MODE_UMIN;

  out_item_t   awaited_answers [$];
  script_row_t script [$];

  bit send_quiet = 1'b0;
  bit recv_quiet = 1'b0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned status_seen [4];
  int unsigned n_clear = 0;
  int unsigned n_append = 0;
  int unsigned n_query = 0;
  int unsigned n_ignored = 0;
  int unsigned peak_count = 0;

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic logic [VALUE_BITS-1:0] pick_extreme(input logic [VALUE_BITS-1:0] a,
                                                         input logic [VALUE_BITS-1:0] b);
    case (shadow_mode)
      MODE_UMIN: return (a <= b) ? a : b;
      MODE_UMAX: return (a >= b) ? a : b;
      MODE_SMIN: return ($signed(a) <= $signed(b)) ? a : b;
      default:   return ($signed(a) >= $signed(b)) ? a : b;
    endcase
  endfunction

  // updates the shadow state; returns 1 when the item yields a result
  function automatic bit predict_answer(input in_item_t it, output out_item_t res);
    int unsigned n, k, span, start, lo, hi, len, lvl, second;
    res = '0;
    case (it.opcode)
      OP_CLEAR: begin
        shadow_count = 0;
        return 1'b0;
      end
      OP_APPEND: begin
        if (shadow_count >= MAX_ELEMENTS) begin
          res.status = STATUS_FULL;
          return 1'b1;
        end
        n = shadow_count;
        shadow_table[0][n] = it.element_value;
        for (k = 1; k < LEVEL_COUNT; k++) begin
          span = 1 << k;
          if (n + 1 < span) break;
          start = n + 1 - span;
          shadow_table[k][start] = pick_extreme(shadow_table[k-1][start],
                                                shadow_table[k-1][start + span / 2]);
        end
        shadow_count = n + 1;
        if (shadow_count > peak_count) peak_count = shadow_count;
        res.status = STATUS_OK;
        return 1'b1;
      end
      OP_QUERY: begin
        lo = it.left_index;
        hi = it.right_index;
        if (!(lo < hi && hi <= shadow_count)) begin
          res.status = STATUS_RANGE;
          return 1'b1;
        end
        len = hi - lo;
        lvl = $clog2(len + 1) - 1;
        if (lvl > LEVEL_COUNT - 1) lvl = LEVEL_COUNT - 1;
        second = hi - (1 << lvl);
        if (second >= MAX_ELEMENTS) second = lo;
        res.range_answer = pick_extreme(shadow_table[lvl][lo], shadow_table[lvl][second]);
        res.status = STATUS_OK;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic in_item_t pack_item(input logic [1:0] op, input logic [31:0] v,
                                         input int unsigned l, input int unsigned r);
    in_item_t it;
    it.opcode = op;
    it.element_value = v;
    it.left_index = l[9:0];
    it.right_index = r[10:0];
    return it;
  endfunction

  function automatic void add_row(input logic [1:0] op, input logic [31:0] v,
                                  input int unsigned l, input int unsigned r,
                                  input bit typed = 1'b0, input logic [31:0] ans = '0,
                                  input status_e st = STATUS_OK);
    script_row_t row;
    row.item = pack_item(op, v, l, r);
    row.typed = typed;
    row.want.range_answer = ans;
    row.want.status = st;
    script.push_back(row);
  endfunction

  // mostly appends and in-range queries; the rest raw noise
  function automatic in_item_t random_item(input int unsigned cap, input int unsigned append_pct,
                                           input bit allow_clear);
    in_item_t it;
    logic [31:0] raw;
    int unsigned r, lo;
    raw = $urandom;
    it.element_value = ($urandom_range(0, 3) == 0) ? (raw & 32'h8000_0007) : raw;
    raw = $urandom;
    it.left_index = raw[9:0];
    it.right_index = raw[20:10];
    it.opcode = OP_QUERY;
    r = $urandom_range(0, 99);
    if (allow_clear && r < 3) begin
      it.opcode = OP_CLEAR;
    end else if (r < 6) begin
      it.opcode = OP_UNUSED;
    end else if (r < 6 + append_pct && shadow_count < cap) begin
      it.opcode = OP_APPEND;
    end else if (r < 94 && shadow_count > 0) begin
      lo = $urandom_range(0, shadow_count - 1);
      it.left_index = lo[9:0];
      raw = $urandom_range(lo + 1, shadow_count);
      it.right_index = raw[10:0];
    end
    return it;
  endfunction

  task automatic issue(input in_item_t it, input bit typed = 1'b0, input out_item_t want = '0);
    out_item_t res;
    int unsigned gap;
    gap = send_quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_item_i <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    if (predict_answer(it, res)) awaited_answers.push_back(typed ? want : res);
    case (it.opcode)
      OP_CLEAR:  n_clear++;
      OP_APPEND: n_append++;
      OP_QUERY:  n_query++;
      default:   n_ignored++;
    endcase
  endtask

  // drain all outstanding results, then let a trailing clear or append finish
  task automatic settle();
    int unsigned waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (awaited_answers.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    if (awaited_answers.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", awaited_answers.size()));
      awaited_answers.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_mode(input mode_e m);
    cfg_wdata_i <= m;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_mode = m;
  endtask

  task automatic fill_table();
    issue(pack_item(OP_CLEAR, '0, 0, 0));
    while (shadow_count < MAX_ELEMENTS) issue(random_item(MAX_ELEMENTS, 88, 1'b0));
    issue(pack_item(OP_APPEND, 32'hFFFF_FFFF, 0, 0), 1'b1, '{range_answer: '0,
                                                           status: STATUS_FULL});
    issue(pack_item(OP_APPEND, 32'h0, 0, 0));
    issue(pack_item(OP_QUERY, '0, 0, MAX_ELEMENTS));
    issue(pack_item(OP_QUERY, '0, MAX_ELEMENTS - 1, MAX_ELEMENTS));
    issue(pack_item(OP_QUERY, '0, 1, MAX_ELEMENTS));
    issue(pack_item(OP_QUERY, '0, 0, MAX_ELEMENTS + 1), 1'b1, '{range_answer: '0,
                                                               status: STATUS_RANGE});
    repeat (40) issue(random_item(MAX_ELEMENTS, 10, 1'b0));
  endtask

  initial begin : result_sink
    out_item_t got;
    out_item_t want;
    int unsigned hold;
    wait (rst_ni === 1'b1);
    forever begin
      hold = recv_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid_o === 1'b1 && out_stall_i == 1'b0));
      got = out_item_o;
      results_seen++;
      status_seen[got.status]++;
      if (awaited_answers.size() == 0) begin
        report_mismatch($sformatf("unexpected result answer %h status %0d",
                                  got.range_answer, got.status));
      end else begin
        want = awaited_answers.pop_front();
        if (got.range_answer !== want.range_answer)
          report_mismatch($sformatf("result %0d answer %h, expected %h", results_seen,
                                    got.range_answer, want.range_answer));
        if (got.status !== want.status)
          report_mismatch($sformatf("result %0d status %0d, expected %0d", results_seen,
                                    got.status, want.status));
      end
    end
  end

  initial begin : stimulus
    in_item_t it;
    int unsigned phase, cap, len;
    phase = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, combine mode still at its reset value (unsigned min)
    add_row(OP_QUERY, '0, 0, 0, 1'b1, '0, STATUS_RANGE);
    add_row(OP_QUERY, '0, 1023, 1024, 1'b1, '0, STATUS_RANGE);
    add_row(OP_APPEND, 32'hFFFF_FFFF, 0, 0, 1'b1, '0, STATUS_OK);
    add_row(OP_APPEND, 32'h0000_0000, 0, 0, 1'b1, '0, STATUS_OK);
    add_row(OP_APPEND, 32'h8000_0000, 0, 0, 1'b1, '0, STATUS_OK);
    add_row(OP_APPEND, 32'h7FFF_FFFF, 0, 0, 1'b1, '0, STATUS_OK);
    add_row(OP_APPEND, 32'h5555_5555, 0, 0);
    add_row(OP_APPEND, 32'hAAAA_AAAA, 0, 0);
    add_row(OP_QUERY, '0, 0, 1, 1'b1, 32'hFFFF_FFFF, STATUS_OK);
    add_row(OP_QUERY, '0, 0, 6);
    add_row(OP_QUERY, '0, 1, 5);
    add_row(OP_QUERY, '0, 2, 4);
    add_row(OP_QUERY, '0, 5, 6, 1'b1, 32'hAAAA_AAAA, STATUS_OK);
    add_row(OP_QUERY, '0, 3, 3, 1'b1, '0, STATUS_RANGE);
    add_row(OP_QUERY, '0, 5, 2, 1'b1, '0, STATUS_RANGE);
    add_row(OP_QUERY, '0, 0, 7, 1'b1, '0, STATUS_RANGE);
    add_row(OP_QUERY, '0, 0, 2047, 1'b1, '0, STATUS_RANGE);
    add_row(OP_UNUSED, 32'hFFFF_FFFF, 1023, 2047);
    add_row(OP_CLEAR, '0, 0, 0);
    add_row(OP_QUERY, '0, 0, 1, 1'b1, '0, STATUS_RANGE);
    add_row(OP_APPEND, 32'h0000_007B, 0, 0, 1'b1, '0, STATUS_OK);
    add_row(OP_QUERY, '0, 0, 1, 1'b1, 32'h0000_007B, STATUS_OK);
    add_row(OP_APPEND, 32'h0000_0001, 0, 0);
    add_row(OP_QUERY, '0, 0, 2);
    foreach (script[i]) issue(script[i].item, script[i].typed, script[i].want);

    // random phases; the first four walk every combine mode, one fills the table
    while (n_clear + n_append + n_query < SMALL_ITEMS) begin
      settle();
      send_quiet = ($urandom_range(0, 3) == 0);
      recv_quiet = ($urandom_range(0, 3) == 0);
      set_mode(phase < 4 ? mode_e'(phase) : mode_e'($urandom_range(0, 3)));
      if (phase == 4) begin
        fill_table();
      end else begin
        if ($urandom_range(0, 1) == 1) begin
          issue(pack_item(OP_CLEAR, $urandom, 0, 0));
        end
        cap = $urandom_range(1, 64);
        len = $urandom_range(20, 80);
        repeat (len) begin
          it = random_item(cap, 44, 1'b1);
          issue(it);
        end
      end
      phase++;
    end
    settle();

    $display("covered %0d appends, %0d queries, %0d clears, %0d ignored items in %0d phases",
             n_append, n_query, n_clear, n_ignored, phase);
    $display("%0d results checked (ok %0d, range %0d, full %0d), table filled to %0d",
             results_seen, status_seen[STATUS_OK], status_seen[STATUS_RANGE],
             status_seen[STATUS_FULL], peak_count);
    if (mismatches == 0) begin
      $display("** sparse_table_range_query_unit: PASSED **");
    end else begin
      $display("** sparse_table_range_query_unit: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #1_200_000;
    $display("** sparse_table_range_query_unit: FAILED **");
    $finish;
  end

endmodule
